FILE: rtl/dos_linear_histogram_top_macros.svh
// Assertion macros for the density-of-states histogram block.
`ifndef DOS_LINEAR_HISTOGRAM_TOP_MACROS_SVH
`define DOS_LINEAR_HISTOGRAM_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define DLH_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define DLH_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

FILE: rtl/dlh_pkg.sv
// Types, constants and widths shared by the histogram block.
package dlh_pkg;

   localparam int NUM_BINS_DEF = 1024;

   // Field widths.
   localparam int CE_W    = 22;
   localparam int SPAN_W  = 22;
   localparam int RB_W    = 10;
   localparam int SUM_W   = 32;
   localparam int SCALE_W = 24;
   localparam int DENS_W  = 32;

   // Doubled coordinates: one LSB is 2^-13 bin.
   localparam int BIN_SHIFT  = 13;
   localparam int FRAC_SHIFT = 16;
   localparam int POS_W      = CE_W + 3;
   localparam int DEN_W      = SPAN_W + 1;
   localparam int OV_W       = BIN_SHIFT + 1;
   localparam int DIVD_W     = OV_W + FRAC_SHIFT;
   localparam int INC_W      = FRAC_SHIFT + 1;
   localparam int CNT_W      = $clog2(DIVD_W);
   localparam int PROD_W     = SUM_W + SCALE_W;

   // Bin index width, wide enough for the largest bin count and for the
   // last bin that a segment can reach.
   localparam int J_W = 17;

   // Command queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd54613;

   // Request kinds.
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Classified command handed from front to back.
   typedef struct packed {
      logic              is_read;
      logic [RB_W-1:0]   read_bin;
      logic [POS_W-1:0]  lo2;
      logic [POS_W-1:0]  hi2;
      logic [DEN_W-1:0]  den;
      logic [J_W-1:0]    first;
      logic [J_W-1:0]    last;
   } cmd_type;

   typedef struct packed {
      logic q_full;
   } front_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIN,
      ST_DIV,
      ST_WRITE,
      ST_RD_MUL,
      ST_RD_OUT
   } back_state_type;

endpackage

FILE: rtl/dlh_channels.sv
// Request and response channel interfaces of the histogram block.
interface dlh_req_if import dlh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CE_W-1:0]   center_energy;
   logic [SPAN_W-1:0] energy_span;
   logic [RB_W-1:0]   read_bin;

   modport source (output valid, req_type, center_energy, energy_span, read_bin,
                   input ready);
   modport sink (input valid, req_type, center_energy, energy_span, read_bin,
                 output ready);
endinterface

interface dlh_rsp_if import dlh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RB_W-1:0]   bin_number;
   logic [DENS_W-1:0] density;

   modport source (output valid, bin_number, density, input ready);
   modport sink (input valid, bin_number, density, output ready);
endinterface

FILE: rtl/dlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/dlh_front.sv
// Front end: accepts request words, works out segment bounds, queues commands.
module dlh_front import dlh_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   dlh_req_if.sink          req_chan,
   input  back_status_type  back_status,
   input  logic             pop,
   output logic             head_valid,
   output cmd_type          head,
   output front_status_type status
);

   localparam logic [J_W-1:0] LAST_BIN = J_W'(NUM_BINS - 1);

   logic [SPAN_W-1:0] span_eff;
   logic [POS_W-1:0]  lo2;
   logic [POS_W-1:0]  hi2;
   logic [POS_W-1:0]  hi2_m1;
   logic [J_W-1:0]    last_raw;
   cmd_type           cmd;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]     count_ff, count_in;
   logic              push;
   logic              full;

   // Segment bounds in doubled units; a zero span counts as one LSB.
   always_comb begin
      span_eff = (req_chan.energy_span == '0) ? SPAN_W'(1) : req_chan.energy_span;
      lo2      = POS_W'({2'b00, req_chan.center_energy, 1'b0}) - POS_W'({3'b000, span_eff});
      hi2      = POS_W'({2'b00, req_chan.center_energy, 1'b0}) + POS_W'({3'b000, span_eff});
      hi2_m1   = hi2 - POS_W'(1);
      last_raw = J_W'(hi2_m1[POS_W-2:BIN_SHIFT]);

      cmd.is_read  = (req_chan.req_type == REQ_READ);
      cmd.read_bin = req_chan.read_bin;
      cmd.lo2      = lo2;
      cmd.hi2      = hi2;
      cmd.den      = {span_eff, 1'b0};
      cmd.first    = lo2[POS_W-1] ? '0 : J_W'(lo2[POS_W-2:BIN_SHIFT]);
      cmd.last     = (last_raw > LAST_BIN) ? LAST_BIN : last_raw;
   end

   // Nothing is taken while the back end clears the histogram.
   assign full           = (count_ff == (QP_W+1)'(QUEUE_DEPTH));
   assign req_chan.ready = !full && !back_status.clearing;
   assign push           = req_chan.valid && req_chan.ready;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QP_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QP_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QP_W+1)'(push) - (QP_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head_valid    = (count_ff != '0);
   assign head          = q_ff[rd_ptr_ff];
   assign status.q_full = full;

endmodule

FILE: rtl/dlh_div.sv
// Restoring divider, one quotient bit per cycle.
module dlh_div import dlh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [INC_W-1:0]  quotient
);

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   // One shift-and-subtract step.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[INC_W-1:0];

endmodule

FILE: rtl/dlh_back.sv
// Back end: clears the histogram, adds sample fractions bin by bin, serves reads.
module dlh_back import dlh_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cmd_type            head,
   output logic               pop,
   input  logic [SCALE_W-1:0] density_scale,
   dlh_rsp_if.source          rsp_chan,
   output back_status_type    status
);

   localparam int AW = $clog2(NUM_BINS);
   localparam int CW = J_W + BIN_SHIFT + 1;
   localparam logic [J_W-1:0] LAST_BIN = J_W'(NUM_BINS - 1);
   localparam logic [J_W-1:0] NUM_BINS_J = J_W'(NUM_BINS);
   localparam logic [CW-1:0]  BIN_SIZE = CW'(1) << BIN_SHIFT;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff;
   logic [J_W-1:0]     j_ff, j_in;
   logic               in_range_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RB_W-1:0]    rsp_bin_ff;
   logic [DENS_W-1:0]  rsp_dens_ff;

   logic signed [CW-1:0] b0, b1, lo_e, hi_e, seg_a, seg_b, ov;
   logic                 ov_pos;
   logic                 bins_done;
   logic                 rsp_load;
   logic [J_W-1:0]       head_bin;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [SUM_W-1:0]     ram_wdata, ram_rdata;
   logic [SUM_W:0]       sum_wide;

   logic                 div_start, div_done;
   logic [INC_W-1:0]     div_quo;
   logic [DENS_W-1:0]    dens_sat;

   dlh_ram #(.WIDTH(SUM_W), .DEPTH(NUM_BINS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dlh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({ov[OV_W-1:0], FRAC_SHIFT'(0)}),
      .divisor  (cmd_ff.den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Overlap of the segment with the current bin, in doubled units.
   always_comb begin
      b0     = $signed({1'b0, j_ff, BIN_SHIFT'(0)});
      b1     = b0 + $signed(BIN_SIZE);
      lo_e   = $signed({{(CW-POS_W){cmd_ff.lo2[POS_W-1]}}, cmd_ff.lo2});
      hi_e   = $signed({{(CW-POS_W){cmd_ff.hi2[POS_W-1]}}, cmd_ff.hi2});
      seg_a  = (lo_e > b0) ? lo_e : b0;
      seg_b  = (hi_e < b1) ? hi_e : b1;
      ov     = seg_b - seg_a;
      ov_pos = !ov[CW-1] && (ov != '0);
      bins_done = (j_ff > cmd_ff.last);
   end

   assign head_bin = J_W'(head.read_bin);
   assign rsp_load = (state_ff == ST_RD_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (j_ff == LAST_BIN) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head_valid) state_in = head.is_read ? ST_RD_MUL : ST_BIN;
         end
         ST_BIN: begin
            if (bins_done) state_in = ST_IDLE;
            else if (ov_pos) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_WRITE;
         end
         ST_WRITE:  state_in = ST_BIN;
         ST_RD_MUL: state_in = ST_RD_OUT;
         ST_RD_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the sequencer: memory, divider and queue controls.
   always_comb begin
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = j_ff[AW-1:0];
      ram_raddr = j_ff[AW-1:0];
      ram_wdata = '0;
      div_start = 1'b0;
      sum_wide  = {1'b0, ram_rdata} + (SUM_W+1)'(div_quo);
      j_in      = j_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            j_in   = j_ff + J_W'(1);
         end
         ST_IDLE: begin
            pop       = head_valid;
            ram_re    = head_valid && head.is_read;
            ram_raddr = head_bin[AW-1:0];
            j_in      = head.first;
         end
         ST_BIN: begin
            if (!bins_done) begin
               if (ov_pos) begin
                  ram_re    = 1'b1;
                  div_start = 1'b1;
               end else begin
                  j_in = j_ff + J_W'(1);
               end
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            j_in      = j_ff + J_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command latch and readout product.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff      <= head;
         in_range_ff <= (head_bin < NUM_BINS_J);
      end
      if (state_ff == ST_RD_MUL) begin
         prod_ff <= in_range_ff ? ({{SCALE_W{1'b0}}, ram_rdata} *
                                   {{SUM_W{1'b0}}, density_scale}) : '0;
      end
      if (rsp_load) begin
         rsp_bin_ff  <= cmd_ff.read_bin;
         rsp_dens_ff <= dens_sat;
      end
   end

   // Shift out the fraction and saturate to 32 bits.
   assign dens_sat = (prod_ff[PROD_W-1:DENS_W+FRAC_SHIFT] != '0) ? '1
                     : prod_ff[DENS_W+FRAC_SHIFT-1:FRAC_SHIFT];

   // Output register; a waiting word holds until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bin_number = rsp_bin_ff;
   assign rsp_chan.density    = rsp_dens_ff;
   assign status.clearing     = (state_ff == ST_CLEAR);

endmodule

FILE: rtl/dos_linear_histogram_top.sv
// Top level of the density-of-states linear interpolation histogram.
//
// Channels: req_chan takes request words (add one sample, or read one bin),
// rsp_chan returns one word per read with the bin number and its density.
// csr_write_enable/csr_write_data set the density scale; write it only
// while the block is idle.
// For every bin that the segment covers, an add word takes one step to
// start the bin, 30 steps of the bit-serial divider for the covered
// fraction, one to see it finish and one write to memory.
// A read word takes one memory read as it leaves the command queue, then
// one multiply and one output register load, which waits while an earlier
// response word is held. The back end ends one read before it takes the next.
// Request words queue two deep in front of the executing back end.
// After reset the histogram memory is cleared, one bin per cycle, through
// all NUM_BINS bins; req_chan.ready stays low during that pass.
// When the receiver stalls, the response word holds in the output register,
// the back end waits on the next read and the queue fills, then ready drops.
module dos_linear_histogram_top import dlh_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   dlh_req_if.sink            req_chan,
   dlh_rsp_if.source          rsp_chan,
   input  logic               csr_write_enable,
   input  logic [SCALE_W-1:0] csr_write_data
);

`include "dos_linear_histogram_top_macros.svh"

   logic [SCALE_W-1:0] density_scale_ff, density_scale_in;
   logic               pop;
   logic               head_valid;
   cmd_type            head;
   front_status_type   front_status;
   back_status_type    back_status;

   // Density scale register.
   assign density_scale_in = csr_write_enable ? csr_write_data : density_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_scale_ff <= SCALE_RESET;
      end else begin
         density_scale_ff <= density_scale_in;
      end
   end

   dlh_front #(.NUM_BINS(NUM_BINS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .back_status (back_status),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head),
      .status      (front_status)
   );

   dlh_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .density_scale (density_scale_ff),
      .rsp_chan      (rsp_chan),
      .status        (back_status)
   );

   // Checks on the clearing pass and the queue.
   `DLH_ASSERT_AFTER_RESET(a_clear_after_reset, back_status.clearing, "no clear after reset")
   `DLH_ASSERT_IMPLIES(a_ready_clear, back_status.clearing, !req_chan.ready, "ready in clear")
   `DLH_ASSERT_IMPLIES(a_ready_full, front_status.q_full, !req_chan.ready, "ready with full queue")

endmodule
